@@ hw/rtl/rcl_pkg.sv @@
// shared constants, register map and digit helper for the rotary combination lock
package rcl_pkg;

  localparam int unsigned CODE_LEN_DEF = 4;
  localparam int unsigned NUM_CODE     = 4;

  localparam logic [3:0]  CODE0_RST   = 4'd8;
  localparam logic [3:0]  CODE1_RST   = 4'd4;
  localparam logic [3:0]  CODE2_RST   = 4'd1;
  localparam logic [3:0]  CODE3_RST   = 4'd3;
  localparam logic [31:0] TIMEOUT_RST = 32'd10000;

  // input actions
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_BUTTON = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  // result events
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_OPENED  = 2'd1;
  localparam logic [1:0] EV_WRONG   = 2'd2;
  localparam logic [1:0] EV_TIMEOUT = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_CODE0   = 3'd0;
  localparam logic [2:0] REG_CODE1   = 3'd1;
  localparam logic [2:0] REG_CODE2   = 3'd2;
  localparam logic [2:0] REG_CODE3   = 3'd3;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;

  // ceil(2^19 / 10), exact quotient for any 16-bit magnitude
  localparam logic [16:0] RECIP10 = 17'd52429;

  // |p| mod 10, mirrored for negative positions
  function automatic logic [3:0] digit_of(input logic signed [15:0] p);
    logic [15:0] mag;
    logic [32:0] prod;
    logic [15:0] quo;
    logic [15:0] rem;
    logic [3:0]  d;
    mag  = p[15] ? 16'(-p) : 16'(p);
    prod = 33'(mag) * 33'(RECIP10);
    quo  = 16'(prod >> 19);
    rem  = mag - 16'((quo << 3) + (quo << 1));
    d    = rem[3:0];
    if (p[15] && d != 4'd0) begin
      d = 4'd10 - d;
    end
    return d;
  endfunction

endpackage

@@ hw/rtl/rotary_combination_lock_core.sv @@
// rotary combination lock: input register, single-pass update logic, result register
// flow: an accepted input is held in the input register, and its result in the result register until taken
// throughput: one item per cycle while out_ready stays high; input and result registers decouple the two channels
// the update path is one pass: a 16x17 reciprocal multiply for the dial digit and a 32-bit tick add
// reset (rst_n low, synchronous): locked, solenoid off, timer stopped, code 8-4-1-3, timeout 10000
// entered digits are not reset; every slot is written before it is compared
module rotary_combination_lock_core
  import rcl_pkg::*;
#(
  parameter int unsigned CODE_LEN = CODE_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic signed [15:0] in_dial_position,
  input  logic               in_long_press,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_solenoid_on,
  output logic               out_entry_mode,
  output logic [2:0]         out_digit_slot,
  output logic [3:0]         out_dial_digit,
  output logic [1:0]         out_event_code,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int unsigned SLOT_W = $clog2(CODE_LEN + 2);

  // configuration
  logic [3:0]  code_r [NUM_CODE];
  logic [31:0] timeout_r;

  // input register
  logic               in_valid_r;
  logic [1:0]         action_r;
  logic signed [15:0] pos_r;
  logic               long_r;

  // lock state
  logic               locked_r, locked_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               turn_up_r, turn_up_nxt;
  logic signed [15:0] last_pos_r, last_pos_nxt;
  logic [3:0]         last_digit_r, last_digit_nxt;
  logic               sol_r, sol_nxt;
  logic               running_r, running_nxt;
  logic [31:0]        ticks_r, ticks_nxt;
  logic [3:0]         entered_r [CODE_LEN];

  // result register
  logic       out_valid_r;
  logic       out_sol_r;
  logic       out_entry_r;
  logic [2:0] out_slot_r;
  logic [3:0] out_digit_r;
  logic [1:0] out_ev_r;

  logic              advance;
  logic [1:0]        ev_nxt;
  logic              dig_we;
  logic [3:0]        pos_digit;
  logic [SLOT_W-1:0] slot_inc;
  logic              code_ok;
  logic [3:0]        code_ext [CODE_LEN];
  logic [31:0]       ticks_sat;
  logic              up;
  logic [SLOT_W+2:0] slot_ext;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  for (genvar g = 0; g < CODE_LEN; g++) begin : g_code
    if (g < NUM_CODE) begin : g_reg
      assign code_ext[g] = code_r[g];
    end else begin : g_zero
      assign code_ext[g] = 4'd0;
    end
  end

  always_comb begin
    code_ok = 1'b1;
    for (int i = 0; i < CODE_LEN; i++) begin
      if (entered_r[i] != code_ext[i]) begin
        code_ok = 1'b0;
      end
    end
  end

  assign pos_digit = digit_of(pos_r);
  assign slot_inc  = slot_r + 1'b1;
  assign up        = pos_r > last_pos_r;
  assign ticks_sat = (ticks_r == '1) ? ticks_r : ticks_r + 32'd1;

  always_comb begin
    locked_nxt     = locked_r;
    slot_nxt       = slot_r;
    turn_up_nxt    = turn_up_r;
    last_pos_nxt   = last_pos_r;
    last_digit_nxt = last_digit_r;
    sol_nxt        = sol_r;
    running_nxt    = running_r;
    ticks_nxt      = ticks_r;
    ev_nxt         = EV_NONE;
    dig_we         = 1'b0;
    case (action_r)
      ACT_SAMPLE: begin
        if (pos_r != last_pos_r && !locked_r) begin
          running_nxt = 1'b1;
          ticks_nxt   = '0;
          if (slot_r == '0) begin
            turn_up_nxt = up;
            slot_nxt    = SLOT_W'(1);
          end else if (turn_up_r != up) begin
            turn_up_nxt = up;
            slot_nxt    = slot_inc;
            // reversal past the last slot closes the entry
            if (slot_inc > SLOT_W'(CODE_LEN)) begin
              sol_nxt    = code_ok;
              ev_nxt     = code_ok ? EV_OPENED : EV_WRONG;
              slot_nxt   = '0;
              locked_nxt = 1'b1;
            end
          end
          last_pos_nxt   = pos_r;
          last_digit_nxt = pos_digit;
          dig_we         = (slot_nxt != '0);
        end
      end
      ACT_BUTTON: begin
        if (!long_r) begin
          locked_nxt = !locked_r;
          if (locked_r) begin
            slot_nxt = '0;
          end
        end
        running_nxt = 1'b1;
        ticks_nxt   = '0;
      end
      ACT_TICK: begin
        if (running_r) begin
          ticks_nxt = ticks_sat;
          if (ticks_sat > timeout_r) begin
            running_nxt = 1'b0;
            locked_nxt  = 1'b1;
            sol_nxt     = 1'b0;
            ev_nxt      = EV_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign slot_ext = {3'b000, slot_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r[0] <= CODE0_RST;
      code_r[1] <= CODE1_RST;
      code_r[2] <= CODE2_RST;
      code_r[3] <= CODE3_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CODE0:   code_r[0] <= cfg_data[3:0];
        REG_CODE1:   code_r[1] <= cfg_data[3:0];
        REG_CODE2:   code_r[2] <= cfg_data[3:0];
        REG_CODE3:   code_r[3] <= cfg_data[3:0];
        REG_TIMEOUT: timeout_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      action_r <= in_action;
      pos_r    <= in_dial_position;
      long_r   <= in_long_press;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r     <= 1'b1;
      slot_r       <= '0;
      turn_up_r    <= 1'b0;
      last_pos_r   <= '0;
      last_digit_r <= 4'd0;
      sol_r        <= 1'b0;
      running_r    <= 1'b0;
      ticks_r      <= '0;
    end else if (advance) begin
      locked_r     <= locked_nxt;
      slot_r       <= slot_nxt;
      turn_up_r    <= turn_up_nxt;
      last_pos_r   <= last_pos_nxt;
      last_digit_r <= last_digit_nxt;
      sol_r        <= sol_nxt;
      running_r    <= running_nxt;
      ticks_r      <= ticks_nxt;
    end
  end

  // the digit lands in the slot the update leaves current
  for (genvar g = 0; g < CODE_LEN; g++) begin : g_entered
    always_ff @(posedge clk) begin
      if (advance && dig_we && slot_nxt == SLOT_W'(g + 1)) begin
        entered_r[g] <= pos_digit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sol_r   <= sol_nxt;
      out_entry_r <= !locked_nxt;
      out_slot_r  <= slot_ext[2:0];
      out_digit_r <= last_digit_nxt;
      out_ev_r    <= ev_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_solenoid_on = out_sol_r;
  assign out_entry_mode  = out_entry_r;
  assign out_digit_slot  = out_slot_r;
  assign out_dial_digit  = out_digit_r;
  assign out_event_code  = out_ev_r;

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_W'(CODE_LEN))
    else $error("slot index beyond code length");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    last_digit_r <= 4'd9)
    else $error("dial digit above nine");

  a_open_energises: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r == EV_OPENED |-> out_sol_r && !out_entry_r)
    else $error("opened event without solenoid or with entry open");

  a_timeout_locks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r == EV_TIMEOUT |-> !out_sol_r && !out_entry_r)
    else $error("timeout event left lock open or solenoid on");

  a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_valid_r |=> out_valid_r)
    else $error("held item not moved into result register");
`endif

endmodule

@@ dv/tb_rotary_combination_lock_core.sv @@
// self-checking testbench for the rotary combination lock core
module tb_rotary_combination_lock_core
  import rcl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         SLOTS      = CODE_LEN_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] pos;
    logic        long_press;
  } lock_item_t;

  typedef struct packed {
    logic       solenoid_on;
    logic       entry_mode;
    logic [2:0] digit_slot;
    logic [3:0] dial_digit;
    logic [1:0] event_code;
  } lock_result_t;

  typedef struct packed {
    logic [NUM_CODE-1:0][3:0] code;
    logic [31:0]              timeout;
    logic                     locked;
    logic [3:0]               slot;
    logic                     turn_up;
    logic [15:0]              last_pos;
    logic [SLOTS-1:0][3:0]    digits;
    logic                     solenoid;
    logic                     timer_on;
    logic [31:0]              idle;
  } lock_state_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_action = ACT_TICK;
  logic signed [15:0] in_dial_position = '0;
  logic               in_long_press = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_solenoid_on;
  logic               out_entry_mode;
  logic [2:0]         out_digit_slot;
  logic [3:0]         out_dial_digit;
  logic [1:0]         out_event_code;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = REG_CODE0;
  logic [31:0]        cfg_data = '0;

  lock_item_t   dial_inputs[$];
  lock_result_t pending_reports[$];
  lock_state_t  live;
  lock_state_t  plan;

  logic in_taken = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_active = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   noise_pct = 0;
  int   queued_cnt = 0;
  int   accepted_cnt = 0;
  int   checked_cnt = 0;
  int   fail_cnt = 0;
  int   opened_cnt = 0;
  int   wrong_cnt = 0;
  int   timeout_cnt = 0;

  rotary_combination_lock_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_dial_position (in_dial_position),
    .in_long_press    (in_long_press),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_solenoid_on  (out_solenoid_on),
    .out_entry_mode   (out_entry_mode),
    .out_digit_slot   (out_digit_slot),
    .out_dial_digit   (out_dial_digit),
    .out_event_code   (out_event_code),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // floor modulo: negative positions mirror onto the dial
  function automatic int digit_at(input int p);
    int m;
    m = p % 10;
    if (m < 0) begin
      m += 10;
    end
    return m;
  endfunction

  function automatic logic [3:0] code_at(input lock_state_t s, input int i);
    return (i < int'(NUM_CODE)) ? s.code[i] : 4'd0;
  endfunction

  function automatic lock_state_t lock_reset();
    lock_state_t s;
    s = '0;
    s.code[0] = CODE0_RST;
    s.code[1] = CODE1_RST;
    s.code[2] = CODE2_RST;
    s.code[3] = CODE3_RST;
    s.timeout = TIMEOUT_RST;
    s.locked = 1'b1;
    return s;
  endfunction

  function automatic void apply_reg(inout lock_state_t s, input logic [2:0] idx,
                                    input logic [31:0] data);
    case (idx)
      REG_CODE0: s.code[0] = data[3:0];
      REG_CODE1: s.code[1] = data[3:0];
      REG_CODE2: s.code[2] = data[3:0];
      REG_CODE3: s.code[3] = data[3:0];
      REG_TIMEOUT: s.timeout = data;
      default: ;
    endcase
  endfunction

  function automatic lock_result_t advance_lock(inout lock_state_t s, input lock_item_t it);
    lock_result_t r;
    logic         up;
    logic         match;
    r = '0;
    r.event_code = EV_NONE;
    case (it.action)
      ACT_SAMPLE: begin
        if (!s.locked && it.pos != s.last_pos) begin
          up = ($signed(it.pos) > $signed(s.last_pos));
          s.timer_on = 1'b1;
          s.idle = '0;
          if (s.slot == 4'd0) begin
            s.turn_up = up;
            s.slot = 4'd1;
          end else if (s.turn_up != up) begin
            s.turn_up = up;
            s.slot = s.slot + 4'd1;
            if (s.slot > SLOTS) begin
              match = 1'b1;
              for (int i = 0; i < SLOTS; i++) begin
                if (s.digits[i] != code_at(s, i)) begin
                  match = 1'b0;
                end
              end
              s.solenoid = match;
              r.event_code = match ? EV_OPENED : EV_WRONG;
              s.slot = 4'd0;
              s.locked = 1'b1;
            end
          end
          s.last_pos = it.pos;
          if (s.slot >= 4'd1 && s.slot <= SLOTS) begin
            s.digits[s.slot - 4'd1] = 4'(digit_at($signed(it.pos)));
          end
        end
      end
      ACT_BUTTON: begin
        if (!it.long_press) begin
          s.locked = !s.locked;
          if (!s.locked) begin
            s.slot = 4'd0;
          end
        end
        s.timer_on = 1'b1;
        s.idle = '0;
      end
      ACT_TICK: begin
        if (s.timer_on) begin
          if (s.idle != 32'hFFFF_FFFF) begin
            s.idle = s.idle + 32'd1;
          end
          if (s.idle > s.timeout) begin
            s.timer_on = 1'b0;
            s.locked = 1'b1;
            s.solenoid = 1'b0;
            r.event_code = EV_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
    r.solenoid_on = s.solenoid;
    r.entry_mode = !s.locked;
    r.digit_slot = s.slot[2:0];
    r.dial_digit = 4'(digit_at($signed(s.last_pos)));
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s expected %0d got %0d", name, want_v, got_v);
      fail_cnt++;
    end
  endtask

  // the plan copy follows the queued stream so that sequences can be shaped
  task automatic push_item(input logic [1:0] action, input logic [15:0] pos,
                           input logic long_press);
    lock_item_t it;
    it = {action, pos, long_press};
    dial_inputs.push_back(it);
    void'(advance_lock(plan, it));
    queued_cnt++;
  endtask

  task automatic queue_noise();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      push_item(ACT_TICK, 16'($urandom), 1'($urandom));
    end else if (pick < 55) begin
      push_item(ACT_UNUSED, 16'($urandom), 1'($urandom));
    end else if (pick < 75) begin
      push_item(ACT_BUTTON, 16'($urandom), 1'b1);
    end else if (pick < 90) begin
      push_item(ACT_SAMPLE, plan.last_pos, 1'($urandom));
    end else begin
      push_item(2'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  // one turn of the dial, ending on the wanted digit
  task automatic queue_turn(input logic up, input int digit, input int max_steps);
    int cur;
    int d;
    int delta;
    int n;
    cur = $signed(plan.last_pos);
    d = up ? (digit - digit_at(cur) + 10) % 10 : (digit_at(cur) - digit + 10) % 10;
    delta = ((d == 0) ? 10 : d) + 10 * $urandom_range(0, 1);
    n = $urandom_range(1, max_steps);
    for (int i = 1; i <= n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        queue_noise();
      end
      push_item(ACT_SAMPLE, 16'(up ? cur + delta * i / n : cur - delta * i / n),
                1'($urandom));
    end
  endtask

  task automatic queue_entry_attempt(input logic aim_open, input int max_steps);
    int   want[SLOTS];
    logic up;
    // relock first so that entry starts from a cleared slot
    if (!plan.locked && plan.slot != 4'd0) begin
      push_item(ACT_BUTTON, 16'($urandom), 1'b0);
    end
    if (plan.locked) begin
      push_item(ACT_BUTTON, 16'($urandom), 1'b0);
    end
    for (int k = 0; k < SLOTS; k++) begin
      want[k] = (aim_open && code_at(plan, k) <= 4'd9) ? int'(code_at(plan, k))
                                                       : int'($urandom_range(0, 9));
    end
    if ($signed(plan.last_pos) > 32000) begin
      up = 1'b0;
    end else if ($signed(plan.last_pos) < -32000) begin
      up = 1'b1;
    end else begin
      up = 1'($urandom);
    end
    for (int k = 0; k <= SLOTS; k++) begin
      if (plan.locked) begin
        return;
      end
      queue_turn(up, (k < SLOTS) ? want[k] : int'($urandom_range(0, 9)), max_steps);
      up = !up;
    end
  endtask

  task automatic queue_random_mix(input int count);
    int stop;
    int r;
    int k;
    stop = queued_cnt + count;
    while (queued_cnt < stop) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        queue_entry_attempt($urandom_range(0, 99) < 60, 3);
      end else if (r < 80) begin
        k = (plan.timeout < 32) ? $urandom_range(1, int'(plan.timeout) + 2)
                                : $urandom_range(1, 6);
        repeat (k) push_item(ACT_TICK, 16'($urandom), 1'($urandom));
      end else begin
        push_item(2'($urandom), 16'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper data bits are random, only the low nibble lands in a code digit
  task automatic set_lock_config(input logic [3:0] c0, input logic [3:0] c1,
                                 input logic [3:0] c2, input logic [3:0] c3,
                                 input logic [31:0] tmo);
    write_reg(REG_CODE0, {28'($urandom), c0});
    write_reg(REG_CODE1, {28'($urandom), c1});
    write_reg(REG_CODE2, {28'($urandom), c2});
    write_reg(REG_CODE3, {28'($urandom), c3});
    write_reg(REG_TIMEOUT, tmo);
  endtask

  task automatic wait_lock_quiet();
    wait (accepted_cnt == queued_cnt && checked_cnt == accepted_cnt);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int count);
    plan = live;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    queue_random_mix(count);
    wait_lock_quiet();
  endtask

  always @(negedge clk) begin : feed_items
    lock_item_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (dial_inputs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = dial_inputs.pop_front();
        in_valid <= 1'b1;
        in_action <= nxt.action;
        in_dial_position <= nxt.pos;
        in_long_press <= nxt.long_press;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // long receiver hold-off so the input side backs up
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (80) @(posedge clk);
    hold_active = 1'b0;
  end

  always @(posedge clk) begin : observe
    lock_item_t   got_in;
    lock_result_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(live, cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        got_in = {in_action, in_dial_position, in_long_press};
        want = advance_lock(live, got_in);
        pending_reports.push_back(want);
        if (want.event_code == EV_OPENED) begin
          opened_cnt++;
        end else if (want.event_code == EV_WRONG) begin
          wrong_cnt++;
        end else if (want.event_code == EV_TIMEOUT) begin
          timeout_cnt++;
        end
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $error("result transfer with no result outstanding");
          fail_cnt++;
        end else begin
          want = pending_reports.pop_front();
          check_field("solenoid_on", 16'(want.solenoid_on), 16'(out_solenoid_on));
          check_field("entry_mode", 16'(want.entry_mode), 16'(out_entry_mode));
          check_field("digit_slot", 16'(want.digit_slot), 16'(out_digit_slot));
          check_field("dial_digit", 16'(want.dial_digit), 16'(out_dial_digit));
          check_field("event_code", 16'(want.event_code), 16'(out_event_code));
          checked_cnt++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    live = lock_reset();
    plan = lock_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed opening at the reset code and timeout
    push_item(ACT_TICK, 16'h0000, 1'b0);
    push_item(ACT_UNUSED, 16'hFFFF, 1'b1);
    push_item(ACT_SAMPLE, 16'h7FFF, 1'b1);
    push_item(ACT_SAMPLE, 16'h8000, 1'b0);
    push_item(ACT_BUTTON, 16'h1234, 1'b1);
    push_item(ACT_BUTTON, 16'h0000, 1'b0);
    push_item(ACT_SAMPLE, 16'h0000, 1'b0);
    push_item(ACT_SAMPLE, 16'h8000, 1'b1);
    push_item(ACT_SAMPLE, 16'h7FFF, 1'b0);
    push_item(ACT_SAMPLE, 16'h7FFF, 1'b0);
    push_item(ACT_TICK, 16'hFFFF, 1'b1);
    push_item(ACT_BUTTON, 16'h0000, 1'b0);
    queue_entry_attempt(1'b1, 1);
    // reopen and relock with the solenoid still energised
    push_item(ACT_BUTTON, 16'h0000, 1'b0);
    push_item(ACT_SAMPLE, 16'h0005, 1'b0);
    push_item(ACT_BUTTON, 16'h0000, 1'b0);
    queue_entry_attempt(1'b0, 1);
    wait_lock_quiet();

    noise_pct = 8;
    set_lock_config(4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                    4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)), 32'd0);
    hold_req = 1'b1;
    run_phase(0, 0, 330);

    set_lock_config(4'd9, 4'd9, 4'd9, 4'd9, 32'd6);
    run_phase(76, 0, 330);

    set_lock_config(4'd0, 4'd0, 4'd0, 4'd0, 32'hFFFF_FFFF);
    run_phase(0, 76, 330);

    set_lock_config(4'd12, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                    4'($urandom_range(0, 9)), 32'($urandom_range(1, 20)));
    run_phase(36, 36, 330);

    set_lock_config(4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                    4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                    32'($urandom_range(1, 12)));
    run_phase(0, 0, 330);

    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d results never arrived", pending_reports.size());
      fail_cnt++;
    end
    $display("lock run: %0d items accepted, %0d results compared over six configurations",
             accepted_cnt, checked_cnt);
    $display("events: %0d opened, %0d wrong code, %0d inactivity timeouts",
             opened_cnt, wrong_cnt, timeout_cnt);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rcl_pkg.sv
hw/rtl/rotary_combination_lock_core.sv
dv/tb_rotary_combination_lock_core.sv
